### sv/stk_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package stk_pkg;

    // Operation codes carried in the action field.
    typedef enum logic [1:0] {
        ACT_PUSH  = 2'd0,
        ACT_POP   = 2'd1,
        ACT_DEDUP = 2'd2
    } action_t;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    // Controller states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_POP_WAIT,
        S_RD_I,
        S_LD_I,
        S_SCAN,
        S_DONE
    } state_t;

    localparam int DATA_W  = 32;
    localparam int DEPTH_W = 7;

    // One finished result, handed from the controller to the output register.
    typedef struct packed {
        status_t                   status;
        logic signed [DATA_W-1:0]  popped_value;
        logic [DEPTH_W-1:0]        depth;
    } result_t;

endpackage

`default_nettype wire

### sv/stk_in_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface stk_in_if;
    logic                                 valid;
    logic                                 ready;
    logic [1:0]                           action;
    logic signed [stk_pkg::DATA_W-1:0]    push_value;

    modport source (output valid, output action, output push_value, input ready);
    modport sink   (input valid, input action, input push_value, output ready);
endinterface

`default_nettype wire

### sv/stk_out_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface stk_out_if;
    logic                                 valid;
    logic                                 ready;
    logic [1:0]                           status;
    logic signed [stk_pkg::DATA_W-1:0]    popped_value;
    logic [stk_pkg::DEPTH_W-1:0]          depth;

    modport source (output valid, output status, output popped_value, output depth,
                    input ready);
    modport sink   (input valid, input status, input popped_value, input depth,
                    output ready);
endinterface

`default_nettype wire

### sv/stk_mem.sv
`timescale 1ns / 1ps
`default_nettype none

// Stack storage: one write port, one read port with registered read data.
// A read at the address being written in the same cycle returns the old data;
// the controller never relies on that case.
module stk_mem #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  wire logic                          clk,
    input  wire logic                          we,
    input  wire logic [AW-1:0]                 waddr,
    input  wire logic [stk_pkg::DATA_W-1:0]    wdata,
    input  wire logic [AW-1:0]                 raddr,
    output logic [stk_pkg::DATA_W-1:0]         rdata
);

    logic [stk_pkg::DATA_W-1:0] mem_reg [DEPTH];
    logic [stk_pkg::DATA_W-1:0] rdata_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // Read port with registered read data.
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

### sv/stk_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

// Stack controller. Push and pop touch one memory entry. Deduplication walks
// the stack from the bottom up: an entry survives when no newer entry above it
// holds the same value, and survivors are written down to a compaction pointer
// that never passes the entry being examined, so the scan above stays intact.
module stk_ctrl #(
    parameter int STACK_DEPTH = 64,
    parameter int AW          = 6,
    parameter int CW          = 7
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    stk_in_if.sink                             op,
    output logic                               res_valid,
    input  wire logic                          res_take,
    output stk_pkg::result_t                   res_data,
    output logic                               mem_we,
    output logic [AW-1:0]                      mem_waddr,
    output logic [stk_pkg::DATA_W-1:0]         mem_wdata,
    output logic [AW-1:0]                      mem_raddr,
    input  wire logic [stk_pkg::DATA_W-1:0]    mem_rdata
);

    stk_pkg::state_t              state_reg, state_next;
    logic [CW-1:0]                count_reg, count_next;
    logic [CW-1:0]                i_reg, i_next;
    logic [CW-1:0]                j_reg, j_next;
    logic [CW-1:0]                w_reg, w_next;
    logic [stk_pkg::DATA_W-1:0]   v_reg, v_next;
    logic                         pend_reg, pend_next;
    stk_pkg::result_t             res_reg, res_next;

    logic [CW-1:0]                count_inc;
    logic [CW-1:0]                count_dec;
    logic [CW-1:0]                i_inc;
    logic [CW-1:0]                w_inc;
    logic                         accept;
    logic                         issue;
    logic                         hit;

    assign count_inc = count_reg + CW'(1);
    assign count_dec = count_reg - CW'(1);
    assign i_inc     = i_reg + CW'(1);
    assign w_inc     = w_reg + CW'(1);
    assign op.ready  = (state_reg == stk_pkg::S_IDLE);
    assign accept    = op.valid && op.ready;
    assign issue     = (j_reg < count_reg);
    assign hit       = pend_reg && (mem_rdata == v_reg);
    assign res_valid = (state_reg == stk_pkg::S_DONE);
    assign res_data  = res_reg;

    // State and datapath registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= stk_pkg::S_IDLE;
            count_reg <= '0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        i_reg   <= i_next;
        j_reg   <= j_next;
        w_reg   <= w_next;
        v_reg   <= v_next;
        res_reg <= res_next;
    end

    // Next state, memory port and result.
    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        w_next     = w_reg;
        v_next     = v_reg;
        pend_next  = 1'b0;
        res_next   = res_reg;
        mem_we     = 1'b0;
        mem_waddr  = count_reg[AW-1:0];
        mem_wdata  = op.push_value;
        mem_raddr  = i_reg[AW-1:0];

        case (state_reg)
            stk_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    res_next.status       = stk_pkg::ST_OK;
                    res_next.popped_value = '0;
                    res_next.depth        = stk_pkg::DEPTH_W'(count_reg);
                    state_next            = stk_pkg::S_DONE;
                    if (op.action == stk_pkg::ACT_PUSH)
                    begin
                        if (count_reg == CW'(STACK_DEPTH))
                        begin
                            res_next.status = stk_pkg::ST_FULL;
                        end
                        else
                        begin
                            mem_we         = 1'b1;
                            count_next     = count_inc;
                            res_next.depth = stk_pkg::DEPTH_W'(count_inc);
                        end
                    end
                    else if (op.action == stk_pkg::ACT_POP)
                    begin
                        if (count_reg == '0)
                        begin
                            res_next.status = stk_pkg::ST_EMPTY;
                        end
                        else
                        begin
                            mem_raddr  = count_dec[AW-1:0];
                            count_next = count_dec;
                            state_next = stk_pkg::S_POP_WAIT;
                        end
                    end
                    else if (op.action == stk_pkg::ACT_DEDUP)
                    begin
                        if (count_reg != '0)
                        begin
                            i_next     = '0;
                            w_next     = '0;
                            state_next = stk_pkg::S_RD_I;
                        end
                    end
                end
            end

            stk_pkg::S_POP_WAIT:
            begin
                res_next.popped_value = mem_rdata;
                res_next.depth        = stk_pkg::DEPTH_W'(count_reg);
                state_next            = stk_pkg::S_DONE;
            end

            // Fetch the entry under examination.
            stk_pkg::S_RD_I:
            begin
                mem_raddr  = i_reg[AW-1:0];
                state_next = stk_pkg::S_LD_I;
            end

            stk_pkg::S_LD_I:
            begin
                v_next     = mem_rdata;
                j_next     = i_inc;
                state_next = stk_pkg::S_SCAN;
            end

            // Stream the newer entries and compare each against the held value.
            stk_pkg::S_SCAN:
            begin
                mem_raddr = j_reg[AW-1:0];
                if (hit || (!issue && !pend_reg))
                begin
                    if (!hit)
                    begin
                        mem_we    = 1'b1;
                        mem_waddr = w_reg[AW-1:0];
                        mem_wdata = v_reg;
                        w_next    = w_inc;
                    end
                    i_next = i_inc;
                    if (i_inc == count_reg)
                    begin
                        count_next     = hit ? w_reg : w_inc;
                        res_next.depth = stk_pkg::DEPTH_W'(hit ? w_reg : w_inc);
                        state_next     = stk_pkg::S_DONE;
                    end
                    else
                    begin
                        state_next = stk_pkg::S_RD_I;
                    end
                end
                else
                begin
                    pend_next = issue;
                    if (issue)
                    begin
                        j_next = j_reg + CW'(1);
                    end
                end
            end

            stk_pkg::S_DONE:
            begin
                if (res_take)
                begin
                    state_next = stk_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = stk_pkg::S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

### sv/stack_with_duplicate_removal_core.sv
// Deduplication of n entries reads each entry in turn, then the entries above it
// stream through the memory read port; a match ends that scan early.
// One item is in work at a time; the next beat can be taken in the cycle after a result
// moves to the output register, which may still be waiting for the sink.
// Reset clears the control state and the entry count; the memory is not cleared.
`timescale 1ns / 1ps
`default_nettype none

module stack_with_duplicate_removal_core #(
    parameter int STACK_DEPTH = 64
) (
    input  wire logic    clk,
    input  wire logic    rst_n,
    stk_in_if.sink       op,
    stk_out_if.source    result
);

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);

    logic                         res_valid;
    logic                         res_take;
    stk_pkg::result_t             res_data;
    logic                         mem_we;
    logic [AW-1:0]                mem_waddr;
    logic [stk_pkg::DATA_W-1:0]   mem_wdata;
    logic [AW-1:0]                mem_raddr;
    logic [stk_pkg::DATA_W-1:0]   mem_rdata;
    logic                         out_valid_reg, out_valid_next;
    stk_pkg::result_t             out_data_reg;

    stk_ctrl #(
        .STACK_DEPTH (STACK_DEPTH),
        .AW          (AW),
        .CW          (CW)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .op        (op),
        .res_valid (res_valid),
        .res_take  (res_take),
        .res_data  (res_data),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

    stk_mem #(
        .DEPTH (STACK_DEPTH),
        .AW    (AW)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // Output register: loads a finished result whenever it is empty or draining.
    assign res_take       = res_valid && (!out_valid_reg || result.ready);
    assign out_valid_next = res_take || (out_valid_reg && !result.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_take)
        begin
            out_data_reg <= res_data;
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.status       = out_data_reg.status;
    assign result.popped_value = out_data_reg.popped_value;
    assign result.depth        = out_data_reg.depth;

    // Every accepted item takes the controller out of its idle state.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        op.valid && op.ready |=> !op.ready)
        else $error("input accepted on two consecutive cycles");

    // A result handed over always appears at the output on the next cycle.
    a_take_loads: assert property (@(posedge clk) disable iff (!rst_n)
        res_take |=> result.valid)
        else $error("result lost between controller and output register");

    // A failed push or pop never reports a value.
    a_fail_no_value: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && (result.status != stk_pkg::ST_OK) |-> result.popped_value == '0)
        else $error("nonzero value with error status");

    // A pop on empty leaves the stack empty.
    a_empty_depth: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && (result.status == stk_pkg::ST_EMPTY) |-> result.depth == '0)
        else $error("empty status with nonzero depth");

endmodule

`default_nettype wire

### test/stack_check_pkg.sv
`timescale 1ns / 1ps

package stack_check_pkg;

    import stk_pkg::*;

    localparam int STACK_DEPTH = 64;

    // The action field has one code that the block ignores.
    localparam logic [1:0] ACT_UNUSED = 2'd3;

    // Keeps a private copy of the stack, works out the result of every accepted
    // operation beat and compares the result beats against it in order.
    class stack_scoreboard;
        logic signed [DATA_W-1:0] entries [STACK_DEPTH];
        int held = 0;
        result_t pending [$];

        int mismatches = 0;
        int checked = 0;
        int pushes = 0;
        int drops = 0;
        int pops = 0;
        int empties = 0;
        int dedups = 0;
        int removed = 0;
        int unused = 0;
        int peak = 0;

        function int outstanding();
            return pending.size();
        endfunction

        function void flag(string what);
            mismatches++;
            if (mismatches <= 10)
                $display("MISMATCH: %s", what);
        endfunction

        // Walk from the top down, keep the newest copy of each value and
        // rebuild the stack bottom-up in the original order.
        function void remove_duplicates();
            logic signed [DATA_W-1:0] kept [$];
            bit seen;
            for (int i = held - 1; i >= 0; i--)
            begin
                seen = 1'b0;
                foreach (kept[k])
                begin
                    if (kept[k] == entries[i])
                        seen = 1'b1;
                end
                if (!seen)
                    kept.push_back(entries[i]);
            end
            removed += held - kept.size();
            held = kept.size();
            for (int k = 0; k < held; k++)
                entries[held - 1 - k] = kept[k];
        endfunction

        // Apply one accepted operation beat and queue the result it must give.
        function void note_op(logic [1:0] act, logic signed [DATA_W-1:0] val);
            result_t r;
            r.status = ST_OK;
            r.popped_value = '0;
            if (act == ACT_PUSH)
            begin
                pushes++;
                if (held >= STACK_DEPTH)
                begin
                    r.status = ST_FULL;
                    drops++;
                end
                else
                begin
                    entries[held] = val;
                    held++;
                end
            end
            else if (act == ACT_POP)
            begin
                pops++;
                if (held == 0)
                begin
                    r.status = ST_EMPTY;
                    empties++;
                end
                else
                begin
                    held--;
                    r.popped_value = entries[held];
                end
            end
            else if (act == ACT_DEDUP)
            begin
                dedups++;
                remove_duplicates();
            end
            else
                unused++;
            r.depth = DEPTH_W'(held);
            if (held > peak)
                peak = held;
            pending.push_back(r);
        endfunction

        // Compare one result beat with the oldest pending expectation.
        function void check_result(logic [1:0] st, logic signed [DATA_W-1:0] pv,
                                   logic [DEPTH_W-1:0] dp);
            result_t want;
            checked++;
            if (pending.size() == 0)
                flag($sformatf("result beat with nothing pending: status %0d popped %0d depth %0d",
                               st, pv, dp));
            else
            begin
                want = pending.pop_front();
                if (st !== want.status || pv !== want.popped_value || dp !== want.depth)
                    flag($sformatf("result %0d: expected status %0d popped %0d depth %0d, got status %0d popped %0d depth %0d",
                                   checked, want.status, want.popped_value, want.depth,
                                   st, pv, dp));
            end
        endfunction

        function void flag_leftovers();
            if (pending.size() != 0)
                flag($sformatf("%0d expected results never arrived", pending.size()));
        endfunction
    endclass

endpackage

### test/testbench.sv
`timescale 1ns / 1ps

module testbench;

    import stk_pkg::*;
    import stack_check_pkg::*;

    typedef enum int {
        MODE_FILL,
        MODE_DRAIN,
        MODE_MIXED,
        MODE_REPEATS
    } seg_mode_t;

    localparam int TOTAL_OPS = 1150;
    localparam int QUIET_FROM = 1000;
    localparam int DRAIN_LIMIT = 20000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    stk_in_if  op_ch ();
    stk_out_if res_ch ();

    stack_scoreboard sb;

    int gap_pct = 0;
    int stall_pct = 0;
    int stall_left = 0;
    int work_items = 0;
    logic signed [DATA_W-1:0] value_pool [6];

    stack_with_duplicate_removal_core #(
        .STACK_DEPTH(STACK_DEPTH)
    ) u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .op     (op_ch),
        .result (res_ch)
    );

    always #4 clk = ~clk;

    // Receiver: random bursts of back-pressure while stall_pct is nonzero.
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            res_ch.ready <= 1'b0;
            stall_left--;
        end
        else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct)
        begin
            res_ch.ready <= 1'b0;
            stall_left = $urandom_range(0, 4);
        end
        else
            res_ch.ready <= 1'b1;
    end

    // Every result beat is checked against the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && res_ch.valid === 1'b1 && res_ch.ready === 1'b1)
            sb.check_result(res_ch.status, res_ch.popped_value, res_ch.depth);
    end

    // Present one operation beat, holding it until the block takes it. An
    // optional idle burst comes first.
    task automatic send_op(input logic [1:0] act, input logic signed [DATA_W-1:0] val);
        if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct)
        begin
            op_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        op_ch.valid      <= 1'b1;
        op_ch.action     <= act;
        op_ch.push_value <= val;
        do
            @(posedge clk);
        while (op_ch.ready !== 1'b1);
        sb.note_op(act, val);
        if (act != ACT_UNUSED)
            work_items++;
    endtask

    // Hold off the sender until every pending result has come back.
    task automatic settle();
        op_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (sb.outstanding() != 0);
    endtask

    // A fresh set of values for a segment, so pushes repeat and deduplication
    // has work to do.
    task automatic refresh_pool();
        logic signed [DATA_W-1:0] corners [4];
        corners = '{32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh0, -32'sd1};
        value_pool[0] = corners[$urandom_range(0, 3)];
        value_pool[1] = corners[$urandom_range(0, 3)];
        for (int i = 2; i < 6; i++)
            value_pool[i] = $urandom;
    endtask

    function automatic logic signed [DATA_W-1:0] pick_value(int pool_pct);
        if ($urandom_range(0, 99) < pool_pct)
            return value_pool[$urandom_range(0, 5)];
        return $urandom;
    endfunction

    function automatic logic [1:0] pick_action(seg_mode_t m);
        int roll;
        int w_push;
        int w_pop;
        int w_dedup;
        roll = $urandom_range(0, 99);
        case (m)
            MODE_FILL:
            begin
                w_push = 85; w_pop = 8;  w_dedup = 5;
            end
            MODE_DRAIN:
            begin
                w_push = 15; w_pop = 78; w_dedup = 5;
            end
            MODE_MIXED:
            begin
                w_push = 45; w_pop = 35; w_dedup = 15;
            end
            default:
            begin
                w_push = 60; w_pop = 15; w_dedup = 23;
            end
        endcase
        if (roll < w_push)
            return ACT_PUSH;
        if (roll < w_push + w_pop)
            return ACT_POP;
        if (roll < w_push + w_pop + w_dedup)
            return ACT_DEDUP;
        return ACT_UNUSED;
    endfunction

    // Hard stop in case the block hangs.
    initial
    begin
        #80_000_000;
        $display("Verification failed");
        $finish;
    end

    initial
    begin
        seg_mode_t mode;
        int seg_len;
        int pcts [3];
        int spin;
        pcts = '{0, 10, 30};
        sb = new();
        op_ch.valid = 1'b0;
        op_ch.action = ACT_PUSH;
        op_ch.push_value = '0;
        res_ch.ready = 1'b0;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty-stack cases, value extremes, the unused code and
        // deduplication with and without repeated values.
        send_op(ACT_POP, 32'sd0);
        send_op(ACT_DEDUP, 32'sd0);
        send_op(ACT_UNUSED, 32'sh1234_5678);
        send_op(ACT_PUSH, 32'sh8000_0000);
        send_op(ACT_PUSH, 32'sh7FFF_FFFF);
        send_op(ACT_PUSH, 32'sh0);
        send_op(ACT_PUSH, -32'sd1);
        send_op(ACT_PUSH, -32'sd1);
        send_op(ACT_PUSH, 32'sh8000_0000);
        send_op(ACT_PUSH, 32'sd5);
        send_op(ACT_PUSH, 32'sh7FFF_FFFF);
        send_op(ACT_DEDUP, 32'sd0);
        send_op(ACT_POP, 32'sd0);
        send_op(ACT_UNUSED, -32'sd1);
        send_op(ACT_PUSH, 32'sh5555_5555);
        send_op(ACT_PUSH, 32'shAAAA_AAAA);
        send_op(ACT_DEDUP, 32'sd0);
        send_op(ACT_POP, 32'sd0);
        send_op(ACT_POP, 32'sd0);
        send_op(ACT_DEDUP, 32'sd0);
        settle();

        // Fill past the top so the overflow drop is always reached.
        gap_pct = 10;
        stall_pct = 10;
        refresh_pool();
        for (int n = 0; n < 72; n++)
            send_op(ACT_PUSH, pick_value(60));

        // Random segments, each with its own operation mix and idling level.
        while (work_items < TOTAL_OPS)
        begin
            mode = seg_mode_t'($urandom_range(0, 3));
            seg_len = $urandom_range(10, 80);
            refresh_pool();
            if (work_items >= QUIET_FROM)
            begin
                gap_pct = 0;
                stall_pct = 0;
            end
            else
            begin
                gap_pct = pcts[$urandom_range(0, 2)];
                stall_pct = pcts[$urandom_range(0, 2)];
            end
            for (int n = 0; n < seg_len && work_items < TOTAL_OPS; n++)
                send_op(pick_action(mode), pick_value(mode == MODE_REPEATS ? 100 : 60));
            if ($urandom_range(0, 5) == 0)
                settle();
        end
        op_ch.valid <= 1'b0;

        // Let the last results drain, then give the block time for strays.
        spin = 0;
        while (sb.outstanding() != 0 && spin < DRAIN_LIMIT)
        begin
            @(posedge clk);
            spin++;
        end
        repeat (20) @(posedge clk);
        sb.flag_leftovers();

        $display("Sent %0d pushes (%0d dropped on full), %0d pops (%0d on empty), %0d dedups removing %0d entries, %0d unused codes.",
                 sb.pushes, sb.drops, sb.pops, sb.empties, sb.dedups, sb.removed, sb.unused);
        $display("Checked %0d results, peak depth %0d, %0d mismatches.",
                 sb.checked, sb.peak, sb.mismatches);
        if (sb.mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

### files.f
sv/stk_pkg.sv
sv/stk_in_if.sv
sv/stk_out_if.sv
sv/stk_mem.sv
sv/stk_ctrl.sv
sv/stack_with_duplicate_removal_core.sv
test/stack_check_pkg.sv
test/testbench.sv
